// ===== rtl/core/swack_pkg.sv =====
`default_nettype none
package swack_pkg;

   localparam int ATTEMPT_W     = 2;
   localparam int BURST_DEFAULT = 3;
   localparam int TIMER_W       = 16;
   localparam int WIN_LEN       = 11;
   localparam int FRAME_LEN     = 10;
   localparam int IDX_W         = 4;
   localparam int QUEUE_DEPTH   = 4;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [TIMER_W-1:0] GAP_RESET   = 16'd100;
   localparam logic [TIMER_W-1:0] FINAL_RESET = 16'd2000;

   localparam logic [7:0] SYNC0     = 8'hAA;
   localparam logic [7:0] SYNC1     = 8'h55;
   localparam logic [7:0] LEN_HI    = 8'h00;
   localparam logic [7:0] LEN_CMD   = 8'h0A;
   localparam logic [7:0] LEN_ACK   = 8'h0B;
   localparam logic [7:0] TAIL_CR   = 8'h0D;
   localparam logic [7:0] TAIL_LF   = 8'h0A;
   localparam logic [7:0] ACK_OK    = 8'h00;

   localparam logic [7:0] CMD_LIGHT  = 8'h02;
   localparam logic [7:0] CMD_PUMP   = 8'h04;
   localparam logic [7:0] CMD_UWB    = 8'h06;
   localparam logic [7:0] CMD_FAN    = 8'h07;
   localparam logic [7:0] CMD_CAMERA = 8'h09;

   typedef enum logic [1:0] {
      FUNC_REQUEST = 2'd0,
      FUNC_RX_BYTE = 2'd1,
      FUNC_TICK    = 2'd2,
      FUNC_FAIL    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      RES_SUCCESS   = 3'd0,
      RES_REFUSED   = 3'd1,
      RES_NO_REPLY  = 3'd2,
      RES_UNKNOWN   = 3'd3,
      RES_SEND_FAIL = 3'd4,
      RES_BUSY      = 3'd5
   } result_code_type;

   typedef enum logic {
      FE_IDLE   = 1'b0,
      FE_ACTIVE = 1'b1
   } front_state_type;

   typedef enum logic {
      CSR_GAP   = 1'b0,
      CSR_FINAL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic            is_result;
      logic [7:0]      cmd;
      result_code_type code;
      logic            on;
   } action_type;

   function automatic logic cmd_known(input logic [7:0] cmd);
      return (cmd == CMD_LIGHT) || (cmd == CMD_PUMP) || (cmd == CMD_UWB) ||
             (cmd == CMD_FAN) || (cmd == CMD_CAMERA);
   endfunction

   function automatic logic [15:0] chk_bytes(input logic [7:0] cmd, input logic on);
      logic [15:0] r;
      r = 16'h0000;
      unique case (cmd)
         CMD_PUMP:   r = on ? 16'hF71F : 16'h36DF;
         CMD_UWB:    r = on ? 16'hF67F : 16'h37BF;
         CMD_FAN:    r = on ? 16'hF7EF : 16'h362F;
         CMD_CAMERA: r = on ? 16'hF38F : 16'h324F;
         default:    r = on ? 16'hF4BF : 16'h357F;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] frame_byte(input logic [7:0] cmd, input logic on,
                                             input logic [IDX_W-1:0] idx);
      logic [15:0] chk;
      logic [7:0]  b;
      chk = chk_bytes(cmd, on);
      b   = 8'h00;
      unique case (idx)
         4'd0:    b = SYNC0;
         4'd1:    b = SYNC1;
         4'd2:    b = LEN_HI;
         4'd3:    b = LEN_CMD;
         4'd4:    b = cmd;
         4'd5:    b = {7'd0, on};
         4'd6:    b = chk[15:8];
         4'd7:    b = chk[7:0];
         4'd8:    b = TAIL_CR;
         4'd9:    b = TAIL_LF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/swack_front.sv =====
`default_nettype none
module swack_front #(
   parameter int BURST_COUNT = swack_pkg::BURST_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [swack_pkg::TIMER_W-1:0]       gap_ticks,
   input  wire  [swack_pkg::TIMER_W-1:0]       final_wait_ticks,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [1:0]                          req_tuser,
   input  wire  [23:0]                         req_tdata,
   input  wire                                 queue_full,
   output logic                                push,
   output swack_pkg::action_type               push_entry
);
   import swack_pkg::*;

   localparam logic [ATTEMPT_W-1:0] BURST_LIMIT = ATTEMPT_W'(BURST_COUNT);

   front_state_type       state_ff, state_in;
   logic [ATTEMPT_W-1:0]  attempt_ff, attempt_in;
   logic [TIMER_W-1:0]    timer_ff, timer_in;
   logic                  nack_ff, nack_in;
   logic [7:0]            job_cmd_ff, job_cmd_in;
   logic                  job_on_ff, job_on_in;
   logic [7:0]            window_ff [WIN_LEN];
   logic [7:0]            window_in [WIN_LEN];

   logic            accept;
   func_type        func;
   logic [7:0]      cmd;
   logic            on;
   logic [7:0]      rx;
   logic            known;
   logic            ack_hit;
   logic            ack_ok;
   logic            expired;
   logic            last_attempt;
   logic [ATTEMPT_W-1:0] next_attempt;
   logic [TIMER_W-1:0]   next_arm;

   assign req_tready   = !queue_full;
   assign accept       = req_tvalid && req_tready;
   assign func         = func_type'(req_tuser);
   assign cmd          = req_tdata[7:0];
   assign on           = req_tdata[8];
   assign rx           = req_tdata[16:9];
   assign known        = cmd_known(cmd);
   // window after the shift: old entries 1..10 plus the new byte
   assign ack_hit      = (window_ff[1] == SYNC0) && (window_ff[2] == SYNC1) &&
                         (window_ff[3] == LEN_HI) && (window_ff[4] == LEN_ACK) &&
                         (window_ff[10] == TAIL_CR) && (rx == TAIL_LF) &&
                         (window_ff[5] == job_cmd_ff);
   assign ack_ok       = (window_ff[6] == ACK_OK);
   assign expired      = (timer_ff <= TIMER_W'(1));
   assign last_attempt = (attempt_ff >= BURST_LIMIT);
   assign next_attempt = attempt_ff + ATTEMPT_W'(1);
   assign next_arm     = (next_attempt < BURST_LIMIT) ? gap_ticks : final_wait_ticks;

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         unique case (state_ff)
            FE_IDLE: begin
               if (func == FUNC_REQUEST && known) state_in = FE_ACTIVE;
            end
            FE_ACTIVE: begin
               unique case (func)
                  FUNC_REQUEST: state_in = FE_ACTIVE;
                  FUNC_RX_BYTE: if (ack_hit && ack_ok) state_in = FE_IDLE;
                  FUNC_TICK:    if (expired && last_attempt) state_in = FE_IDLE;
                  FUNC_FAIL:    state_in = FE_IDLE;
               endcase
            end
         endcase
      end
   end

   always_comb begin
      attempt_in = attempt_ff;
      timer_in   = timer_ff;
      nack_in    = nack_ff;
      job_cmd_in = job_cmd_ff;
      job_on_in  = job_on_ff;
      window_in  = window_ff;
      push       = 1'b0;
      push_entry = '{is_result: 1'b1, cmd: job_cmd_ff, code: RES_SUCCESS, on: job_on_ff};
      if (accept) begin
         unique case (func)
            FUNC_REQUEST: begin
               if (state_ff == FE_ACTIVE) begin
                  push       = 1'b1;
                  push_entry = '{is_result: 1'b1, cmd: cmd, code: RES_BUSY, on: on};
               end else begin
                  for (int i = 0; i < WIN_LEN; i++) window_in[i] = 8'h00;
                  push = 1'b1;
                  if (!known) begin
                     push_entry = '{is_result: 1'b1, cmd: cmd, code: RES_UNKNOWN, on: on};
                  end else begin
                     job_cmd_in = cmd;
                     job_on_in  = on;
                     nack_in    = 1'b0;
                     attempt_in = ATTEMPT_W'(1);
                     timer_in   = (BURST_LIMIT > ATTEMPT_W'(1)) ? gap_ticks
                                                                : final_wait_ticks;
                     push_entry = '{is_result: 1'b0, cmd: cmd, code: RES_SUCCESS, on: on};
                  end
               end
            end
            FUNC_RX_BYTE: begin
               for (int i = 0; i < WIN_LEN - 1; i++) window_in[i] = window_ff[i+1];
               window_in[WIN_LEN-1] = rx;
               if (state_ff == FE_ACTIVE && ack_hit) begin
                  if (ack_ok) begin
                     push       = 1'b1;
                     attempt_in = '0;
                     timer_in   = '0;
                     nack_in    = 1'b0;
                  end else begin
                     nack_in = 1'b1;
                  end
               end
            end
            FUNC_TICK: begin
               if (state_ff == FE_ACTIVE) begin
                  if (!expired) begin
                     timer_in = timer_ff - TIMER_W'(1);
                  end else if (!last_attempt) begin
                     attempt_in = next_attempt;
                     timer_in   = next_arm;
                     push       = 1'b1;
                     push_entry = '{is_result: 1'b0, cmd: job_cmd_ff, code: RES_SUCCESS,
                                    on: job_on_ff};
                  end else begin
                     push       = 1'b1;
                     push_entry.code = nack_ff ? RES_REFUSED : RES_NO_REPLY;
                     attempt_in = '0;
                     timer_in   = '0;
                     nack_in    = 1'b0;
                  end
               end
            end
            FUNC_FAIL: begin
               if (state_ff == FE_ACTIVE) begin
                  push            = 1'b1;
                  push_entry.code = RES_SEND_FAIL;
                  attempt_in      = '0;
                  timer_in        = '0;
                  nack_in         = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FE_IDLE;
         attempt_ff <= '0;
         timer_ff   <= '0;
         nack_ff    <= 1'b0;
         job_cmd_ff <= '0;
         job_on_ff  <= 1'b0;
         for (int i = 0; i < WIN_LEN; i++) window_ff[i] <= 8'h00;
      end else begin
         state_ff   <= state_in;
         attempt_ff <= attempt_in;
         timer_ff   <= timer_in;
         nack_ff    <= nack_in;
         job_cmd_ff <= job_cmd_in;
         job_on_ff  <= job_on_in;
         window_ff  <= window_in;
      end
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == FE_IDLE |-> attempt_ff == '0 && !nack_ff)
      else $error("idle front holds job progress");

   a_active_attempt: assert property (@(posedge clock) disable iff (reset)
      state_ff == FE_ACTIVE |-> attempt_ff != '0 && attempt_ff <= BURST_LIMIT)
      else $error("attempt count out of range");

   a_start_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == FE_ACTIVE) |-> $past(push) && !$past(push_entry.is_result))
      else $error("job started without a frame");

endmodule
`default_nettype wire

// ===== rtl/core/swack_queue.sv =====
`default_nettype none
module swack_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  swack_pkg::action_type    push_entry,
   input  wire                      pop,
   output swack_pkg::action_type    head,
   output logic                     not_empty,
   output logic                     full
);
   import swack_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   action_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head      = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push)
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop)
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

endmodule
`default_nettype wire

// ===== rtl/core/swack_back.sv =====
`default_nettype none
module swack_back (
   input  wire                      clock,
   input  wire                      reset,
   input  swack_pkg::action_type    head,
   input  wire                      not_empty,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic                     rsp_tlast,
   output logic [0:0]               rsp_tuser,
   output logic [15:0]              rsp_tdata
);
   import swack_pkg::*;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic              kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [2:0]        code_ff, code_in;
   logic              on_ff, on_in;
   logic              out_free, load, frame_end;

   assign out_free  = !valid_ff || rsp_tready;
   assign load      = out_free && not_empty;
   assign frame_end = (idx_ff == IDX_W'(FRAME_LEN - 1));
   assign pop       = load && (head.is_result || frame_end);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_tready;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      code_in  = code_ff;
      on_in    = on_ff;
      if (load) begin
         valid_in = 1'b1;
         kind_in  = head.is_result;
         if (head.is_result) begin
            byte_in = 8'h00;
            last_in = 1'b0;
            code_in = head.code;
            on_in   = head.on;
         end else begin
            byte_in = frame_byte(head.cmd, head.on, idx_ff);
            last_in = frame_end;
            code_in = RES_SUCCESS;
            on_in   = 1'b0;
            idx_in  = frame_end ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      code_ff <= code_in;
      on_ff   <= on_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {4'd0, on_ff, code_ff, byte_ff};

   a_result_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff |-> !last_ff)
      else $error("job result marked as frame end");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < IDX_W'(FRAME_LEN))
      else $error("frame byte index out of range");

endmodule
`default_nettype wire

// ===== rtl/core/switch_command_ack_engine.sv =====
`default_nettype none
// Switch command and acknowledge engine. A request item (tuser = request) starts a job:
// the 10-byte command frame is sent as ten rsp items (tuser = 0, tlast on the tenth),
// then received bytes are matched through an 11-byte window for an ack of the same
// command, and tick items count down the wait before each resend (up to BURST_COUNT
// attempts). Each job ends in one result item (tuser = 1). Every request, byte, tick or
// failure report is taken at once unless the queue is full; requests and resends queue
// one frame entry, which drains at one byte per cycle while rsp_tready is high, so
// req_tready drops only while the four-entry front-to-emitter action queue is full.
module switch_command_ack_engine #(
   parameter int BURST_COUNT = swack_pkg::BURST_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [1:0]                          req_tuser,   // func
   input  wire  [23:0]                         req_tdata,   // cmd_code, turn_on, rx_byte
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic                                rsp_tlast,   // last_of_frame
   output logic [0:0]                          rsp_tuser,   // kind
   output logic [15:0]                         rsp_tdata,   // tx_byte, result_code, result_on
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [swack_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import swack_pkg::*;

   logic [TIMER_W-1:0] gap_ff, gap_in;
   logic [TIMER_W-1:0] final_ff, final_in;
   csr_index_type      csr_index;
   logic               csr_write;

   logic        queue_full, queue_not_empty, push, pop;
   action_type  push_entry, head;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      gap_in   = gap_ff;
      final_in = final_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAP:   gap_in   = csr_pwdata[TIMER_W-1:0];
            CSR_FINAL: final_in = csr_pwdata[TIMER_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_GAP:   csr_prdata = {16'd0, gap_ff};
         CSR_FINAL: csr_prdata = {16'd0, final_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= GAP_RESET;
         final_ff <= FINAL_RESET;
      end else begin
         gap_ff   <= gap_in;
         final_ff <= final_in;
      end
   end

   swack_front #(.BURST_COUNT(BURST_COUNT)) u_front (
      .clock            (clock),
      .reset            (reset),
      .gap_ticks        (gap_ff),
      .final_wait_ticks (final_ff),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tuser        (req_tuser),
      .req_tdata        (req_tdata),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   swack_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (queue_not_empty),
      .full       (queue_full)
   );

   swack_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (queue_not_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== tb/switch_command_ack_engine_tb.sv =====
module switch_command_ack_engine_tb;
   import swack_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic            kind;
      logic [7:0]      tx;
      logic            eof;
      result_code_type code;
      logic            on;
   } engine_out_type;

   typedef struct {
      func_type       f;
      logic [7:0]     c;
      logic           o;
      logic [7:0]     b;
      logic           fixed;
      engine_out_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = 2'd0;
   logic [23:0] req_tdata = 24'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic [15:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // tb-side tag riding along with each item on the req bus
   logic           row_fixed = 1'b0;
   engine_out_type row_want = '0;

   // engine state as predicted
   logic [15:0] gap_r = GAP_RESET;
   logic [15:0] final_r = FINAL_RESET;
   logic        eng_active = 1'b0;
   int          eng_attempt = 0;
   logic [15:0] eng_timer = 16'd0;
   logic        eng_nack = 1'b0;
   logic [7:0]  eng_cmd = 8'd0;
   logic        eng_on = 1'b0;
   logic [7:0]  ack_win [WIN_LEN];

   engine_out_type owed_out [$];
   dir_row_type    rows [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          sent = 0;
   bit          quiet = 1'b0;
   int          hold_req = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   logic [7:0]  switch_cmds [5] = '{CMD_LIGHT, CMD_PUMP, CMD_UWB, CMD_FAN, CMD_CAMERA};
   int          phase_gap [5] = '{1, 0, 2, 65535, 3};
   int          phase_final [5] = '{1, 0, 65535, 3, 5};

   switch_command_ack_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      foreach (ack_win[i]) ack_win[i] = 8'd0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 9);
      end
   end

   function automatic logic is_switch_cmd(input logic [7:0] c);
      case (c)
         CMD_LIGHT, CMD_PUMP, CMD_UWB, CMD_FAN, CMD_CAMERA: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [15:0] switch_check(input logic [7:0] c, input logic o);
      case (c)
         CMD_PUMP:   return o ? 16'hF71F : 16'h36DF;
         CMD_UWB:    return o ? 16'hF67F : 16'h37BF;
         CMD_FAN:    return o ? 16'hF7EF : 16'h362F;
         CMD_CAMERA: return o ? 16'hF38F : 16'h324F;
         default:    return o ? 16'hF4BF : 16'h357F;
      endcase
   endfunction

   task automatic queue_frame();
      logic [15:0] chk;
      logic [7:0]  fr [FRAME_LEN];
      chk = switch_check(eng_cmd, eng_on);
      fr = '{SYNC0, SYNC1, LEN_HI, LEN_CMD, eng_cmd, {7'd0, eng_on},
             chk[15:8], chk[7:0], TAIL_CR, TAIL_LF};
      foreach (fr[i])
         owed_out.push_back('{1'b0, fr[i], i == FRAME_LEN - 1, RES_SUCCESS, 1'b0});
   endtask

   task automatic arm_wait();
      eng_timer = (eng_attempt < BURST_DEFAULT) ? gap_r : final_r;
   endtask

   task automatic close_job(input result_code_type code);
      owed_out.push_back('{1'b1, 8'd0, 1'b0, code, eng_on});
      eng_active = 1'b0;
      eng_attempt = 0;
      eng_timer = 16'd0;
      eng_nack = 1'b0;
   endtask

   task automatic advance_engine(input func_type f, input logic [7:0] c, input logic o,
                                 input logic [7:0] b);
      case (f)
         FUNC_REQUEST: begin
            if (eng_active) begin
               owed_out.push_back('{1'b1, 8'd0, 1'b0, RES_BUSY, o});
            end else begin
               foreach (ack_win[i]) ack_win[i] = 8'd0;
               if (!is_switch_cmd(c)) begin
                  owed_out.push_back('{1'b1, 8'd0, 1'b0, RES_UNKNOWN, o});
               end else begin
                  eng_active = 1'b1;
                  eng_cmd = c;
                  eng_on = o;
                  eng_nack = 1'b0;
                  eng_attempt = 1;
                  arm_wait();
                  queue_frame();
               end
            end
         end
         FUNC_RX_BYTE: begin
            for (int i = 0; i < WIN_LEN - 1; i++) ack_win[i] = ack_win[i+1];
            ack_win[WIN_LEN-1] = b;
            if (eng_active && ack_win[0] == SYNC0 && ack_win[1] == SYNC1 &&
                ack_win[2] == LEN_HI && ack_win[3] == LEN_ACK && ack_win[9] == TAIL_CR &&
                ack_win[10] == TAIL_LF && ack_win[4] == eng_cmd) begin
               if (ack_win[5] == ACK_OK) close_job(RES_SUCCESS);
               else eng_nack = 1'b1;
            end
         end
         FUNC_TICK: begin
            if (eng_active) begin
               if (eng_timer > 16'd1) begin
                  eng_timer--;
               end else if (eng_attempt < BURST_DEFAULT) begin
                  eng_attempt++;
                  arm_wait();
                  queue_frame();
               end else begin
                  close_job(eng_nack ? RES_REFUSED : RES_NO_REPLY);
               end
            end
         end
         default: begin
            if (eng_active) close_job(RES_SEND_FAIL);
         end
      endcase
   endtask

   task automatic take_output();
      engine_out_type got;
      engine_out_type want;
      got = '{rsp_tuser[0], rsp_tdata[7:0], rsp_tlast, result_code_type'(rsp_tdata[10:8]),
              rsp_tdata[11]};
      if (owed_out.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("rsp item with nothing owed: %p", got);
      end else begin
         want = owed_out.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("rsp mismatch: expected %p, got %p", want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            advance_engine(func_type'(req_tuser), req_tdata[7:0], req_tdata[8],
                           req_tdata[16:9]);
            if (row_fixed) begin
               void'(owed_out.pop_back());
               owed_out.push_back(row_want);
            end
         end
         if (rsp_tvalid && rsp_tready) take_output();
      end
   end

   task automatic send_item(input func_type f, input logic [7:0] c, input logic o,
                            input logic [7:0] b, input logic fixed,
                            input engine_out_type want);
      if (!quiet && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {7'd0, b, o, c};
      row_fixed <= fixed;
      row_want <= want;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic add_row(input func_type f, input logic [7:0] c, input logic o,
                          input logic [7:0] b, input logic fixed, input result_code_type code,
                          input logic fon);
      dir_row_type r;
      r.f = f;
      r.c = c;
      r.o = o;
      r.b = b;
      r.fixed = fixed;
      r.want = '{1'b1, 8'd0, 1'b0, code, fon};
      rows.push_back(r);
   endtask

   task automatic send_ack(input logic [7:0] c, input logic [7:0] ok);
      logic [7:0] frm [WIN_LEN];
      frm = '{SYNC0, SYNC1, LEN_HI, LEN_ACK, c, ok, 8'($urandom), 8'($urandom),
              8'($urandom), TAIL_CR, TAIL_LF};
      if ($urandom_range(99) < 10) frm[$urandom_range(WIN_LEN - 1)] = 8'($urandom);
      foreach (frm[i]) send_item(FUNC_RX_BYTE, 8'($urandom), 1'($urandom), frm[i], 1'b0, '0);
   endtask

   task automatic run_job();
      logic [7:0] jc;
      int         pick;
      jc = ($urandom_range(99) < 85) ? switch_cmds[$urandom_range(4)] : 8'($urandom);
      send_item(FUNC_REQUEST, jc, 1'($urandom), 8'($urandom), 1'b0, '0);
      repeat ($urandom_range(2, 6)) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_ack(($urandom_range(99) < 80) ? jc : 8'($urandom),
                     ($urandom_range(99) < 40) ? ACK_OK : 8'($urandom_range(1, 255)));
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 6))
               send_item(FUNC_TICK, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0, '0);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4))
               send_item(FUNC_RX_BYTE, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0, '0);
         end else if (pick < 95) begin
            send_item(FUNC_REQUEST,
                      ($urandom_range(1)) ? switch_cmds[$urandom_range(4)] : 8'($urandom),
                      1'($urandom), 8'($urandom), 1'b0, '0);
         end else begin
            send_item(FUNC_FAIL, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0, '0);
         end
      end
   endtask

   // ends any running job, then lets the block drain completely
   task automatic end_phase();
      send_item(FUNC_FAIL, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0, '0);
      req_tvalid <= 1'b0;
      while (owed_out.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'd0, v}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("csr readback at %0d: expected %h, got %h", idx, v, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == CSR_GAP) gap_r = v;
      else final_r = v;
      @(posedge clock);
   endtask

   initial begin
      int start;
      add_row(FUNC_TICK, 8'h00, 1'b0, 8'h00, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_FAIL, 8'hFF, 1'b1, 8'hFF, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_REQUEST, 8'h00, 1'b0, 8'h00, 1'b1, RES_UNKNOWN, 1'b0);
      add_row(FUNC_REQUEST, 8'hFF, 1'b1, 8'hFF, 1'b1, RES_UNKNOWN, 1'b1);
      add_row(FUNC_REQUEST, CMD_LIGHT, 1'b1, 8'h00, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_REQUEST, CMD_PUMP, 1'b0, 8'h00, 1'b1, RES_BUSY, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, SYNC0, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, SYNC1, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, LEN_HI, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, LEN_ACK, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, CMD_LIGHT, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, ACK_OK, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, 8'h11, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, 8'h22, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, 8'h33, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, TAIL_CR, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'h00, 1'b0, TAIL_LF, 1'b1, RES_SUCCESS, 1'b1);
      add_row(FUNC_REQUEST, CMD_CAMERA, 1'b0, 8'h00, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_RX_BYTE, 8'hFF, 1'b1, 8'hFF, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_TICK, 8'h00, 1'b0, 8'h00, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_FAIL, 8'h00, 1'b0, 8'h00, 1'b1, RES_SEND_FAIL, 1'b0);
      add_row(FUNC_REQUEST, CMD_FAN, 1'b1, 8'h00, 1'b0, RES_SUCCESS, 1'b0);
      add_row(FUNC_REQUEST, CMD_UWB, 1'b1, 8'h00, 1'b1, RES_BUSY, 1'b1);
      add_row(FUNC_FAIL, 8'h00, 1'b0, 8'h00, 1'b1, RES_SEND_FAIL, 1'b1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_item(rows[i].f, rows[i].c, rows[i].o, rows[i].b, rows[i].fixed, rows[i].want);
      end_phase();

      foreach (phase_gap[p]) begin
         write_reg(CSR_GAP, 16'(phase_gap[p]));
         write_reg(CSR_FINAL, 16'(phase_final[p]));
         quiet = (p == 4);
         if (p == 0) hold_req++;
         start = sent;
         while (sent - start < 12) run_job();
         end_phase();
      end
      quiet = 1'b0;

      if (owed_out.size() != 0) begin
         mismatches++;
         $display("rsp items still owed at end: %0d", owed_out.size());
      end
      if (mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
